// File: rtl/core/b64le_pkg.sv
// ----------------------------------------------------------------------------
// b64le_pkg
// Shared types, constants and the alphabet lookup of the base64 line encoder.
// ----------------------------------------------------------------------------
package b64le_pkg;

   localparam int unsigned CharWidth        = 8;
   localparam int unsigned SextetWidth      = 6;
   localparam int unsigned QueueDepthDef    = 2;
   localparam int unsigned GroupChars       = 4;

   localparam logic [7:0] MaxLineCharsReset = 8'd76;
   localparam logic [7:0] PadChar           = 8'd61;
   localparam logic [7:0] NewlineChar       = 8'd10;

   localparam logic [63:0][7:0] Alphabet = {
      "/", "+", "9", "8", "7", "6", "5", "4", "3", "2", "1", "0",
      "z", "y", "x", "w", "v", "u", "t", "s", "r", "q", "p", "o",
      "n", "m", "l", "k", "j", "i", "h", "g", "f", "e", "d", "c",
      "b", "a", "Z", "Y", "X", "W", "V", "U", "T", "S", "R", "Q",
      "P", "O", "N", "M", "L", "K", "J", "I", "H", "G", "F", "E",
      "D", "C", "B", "A"
   };

   // One encoded group handed from front to back.
   typedef struct packed {
      logic [GroupChars-1:0][SextetWidth-1:0] sextet;
      logic [1:0]                             held;    // bytes held before the closing byte
      logic                                   newline;
   } group_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] sym(input logic [SextetWidth-1:0] v);
      return Alphabet[v];
   endfunction

endpackage

// File: rtl/core/b64le_req_if.sv
// ----------------------------------------------------------------------------
// b64le_req_if
// Byte channel into the encoder: valid/ready with one byte and an end flag.
// ----------------------------------------------------------------------------
interface b64le_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/core/b64le_rsp_if.sv
// ----------------------------------------------------------------------------
// b64le_rsp_if
// Character channel out of the encoder: valid/ready with one character.
// ----------------------------------------------------------------------------
interface b64le_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_of_run;

   modport source (output valid, output out_char, output last_of_run, input ready);
   modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

// File: rtl/core/b64le_front.sv
// ----------------------------------------------------------------------------
// b64le_front
// Accepts bytes, holds partial groups, tracks line length and queues groups.
// ----------------------------------------------------------------------------
module b64le_front (
   input  logic                        clock,
   input  logic                        reset,
   b64le_req_if.sink                   req,
   input  logic                        csr_wr_en,
   input  logic [7:0]                  csr_wr_data,
   input  b64le_pkg::queue_status_type q_status,
   output logic                        q_push,
   output b64le_pkg::group_type        q_wdata
);
   import b64le_pkg::*;

   logic [7:0]  max_line_ff, max_line_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  second_ff, second_in;
   logic [1:0]  held_ff, held_in;
   logic [7:0]  line_ff, line_in;
   logic        accept, closes;
   logic [7:0]  b0, b1, b2;
   logic [8:0]  count;
   logic        newline;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;
   assign closes    = (held_ff == 2'd2) || req.last_byte;

   always_comb begin
      case (held_ff)
         2'd0: begin
            b0 = req.data_byte; b1 = 8'd0; b2 = 8'd0;
         end
         2'd1: begin
            b0 = first_ff; b1 = req.data_byte; b2 = 8'd0;
         end
         default: begin
            b0 = first_ff; b1 = second_ff; b2 = req.data_byte;
         end
      endcase
   end

   assign count   = {1'b0, line_ff} + 9'd4;
   assign newline = ({1'b0, count} + 10'd4) > {2'b00, max_line_ff};

   always_comb begin
      q_wdata.sextet[0] = b0[7:2];
      q_wdata.sextet[1] = {b0[1:0], b1[7:4]};
      q_wdata.sextet[2] = {b1[3:0], b2[7:6]};
      q_wdata.sextet[3] = b2[5:0];
      q_wdata.held      = held_ff;
      q_wdata.newline   = newline;
   end

   assign q_push = accept && closes;

   always_comb begin
      max_line_in = csr_wr_en ? csr_wr_data : max_line_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      held_in     = held_ff;
      line_in     = line_ff;
      if (accept) begin
         if (!closes) begin
            if (held_ff == 2'd0) begin
               first_in = req.data_byte;
            end else begin
               second_in = req.data_byte;
            end
            held_in = held_ff + 2'd1;
         end else begin
            held_in = 2'd0;
            if (req.last_byte || newline) begin
               line_in = 8'd0;
            end else begin
               line_in = count[7:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_line_ff <= MaxLineCharsReset;
         held_ff     <= 2'd0;
         line_ff     <= 8'd0;
      end else begin
         max_line_ff <= max_line_in;
         held_ff     <= held_in;
         line_ff     <= line_in;
      end
      first_ff  <= first_in;
      second_ff <= second_in;
   end

endmodule

// File: rtl/core/b64le_queue.sv
// ----------------------------------------------------------------------------
// b64le_queue
// Small group queue between front and back.
// ----------------------------------------------------------------------------
module b64le_queue #(
   parameter int unsigned Depth = b64le_pkg::QueueDepthDef
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  b64le_pkg::group_type        wdata,
   input  logic                        pop,
   output b64le_pkg::group_type        rdata,
   output b64le_pkg::queue_status_type status
);
   import b64le_pkg::*;

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

   group_type             mem_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign status.full  = (cnt_ff == FullCnt);
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rdata        = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: rtl/core/b64le_back.sv
// ----------------------------------------------------------------------------
// b64le_back
// Serializes queued groups into characters through an output register.
// ----------------------------------------------------------------------------
module b64le_back (
   input  logic                        clock,
   input  logic                        reset,
   input  b64le_pkg::group_type        q_rdata,
   input  b64le_pkg::queue_status_type q_status,
   output logic                        q_pop,
   b64le_rsp_if.source                 rsp
);
   import b64le_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       advance, load, final_char;
   logic [7:0] next_char;

   assign advance    = !valid_ff || rsp.ready;
   assign load       = advance && !q_status.empty;
   assign final_char = q_rdata.newline ? (idx_ff == 3'd4) : (idx_ff == 3'd3);
   assign q_pop      = load && final_char;

   always_comb begin
      case (idx_ff)
         3'd0:    next_char = sym(q_rdata.sextet[0]);
         3'd1:    next_char = sym(q_rdata.sextet[1]);
         3'd2:    next_char = (q_rdata.held != 2'd0) ? sym(q_rdata.sextet[2]) : PadChar;
         3'd3:    next_char = (q_rdata.held == 2'd2) ? sym(q_rdata.sextet[3]) : PadChar;
         default: next_char = NewlineChar;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = load;
         if (load) begin
            char_in = next_char;
            last_in = final_char;
            idx_in  = final_char ? 3'd0 : idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.out_char    = char_ff;
   assign rsp.last_of_run = last_ff;

endmodule

// File: rtl/core/base64_line_wrapped_encoder.sv
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder
// Byte stream to base64 text with newline insertion at a programmable width.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the group queue has room; a byte that
// only completes nothing is absorbed without queueing. Each third byte, or a byte
// flagged last, queues one group, which the back end sends as four characters
// (five with a trailing newline), one per cycle while the receiver is ready,
// so the single character output register sets the pace over a long message.
// A newline follows a group when another group would pass csr_wr_data's line
// limit (reset 76); the line count clears at message end. The user must write
// the limit through csr_wr_en only while the block is idle; nothing enforces it.
module base64_line_wrapped_encoder #(
   parameter int unsigned QueueDepth = b64le_pkg::QueueDepthDef
) (
   input  logic       clock,
   input  logic       reset,
   b64le_req_if.sink  req_chan,
   b64le_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import b64le_pkg::*;

   group_type        q_wdata, q_rdata;
   queue_status_type q_status;
   logic             q_push, q_pop;

   b64le_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_wdata     (q_wdata)
   );

   b64le_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   b64le_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_rdata  (q_rdata),
      .q_status (q_status),
      .q_pop    (q_pop),
      .rsp      (rsp_chan)
   );

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue full and empty at once");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("group pushed into full queue");

   a_newline_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.out_char == NewlineChar) |-> rsp_chan.last_of_run)
      else $error("newline not last of run");

   a_pop_ends_run: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (rsp_chan.valid && rsp_chan.last_of_run))
      else $error("group retired without closing beat");

endmodule

// File: tb/b64le_stream_checker.sv
// ----------------------------------------------------------------------------
// b64le_stream_checker
// Watches the byte and character channels of the base64 line encoder, works
// out the characters each accepted byte beat must produce (alphabet symbols,
// '=' padding, newlines at the line limit) and compares every character beat
// against the oldest one due. Hands its counts to the test top.
// ----------------------------------------------------------------------------
module b64le_stream_checker (
   input  logic       clock,
   input  logic       reset,
   b64le_req_if       req_mon,
   b64le_rsp_if       rsp_mon,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   output int         mismatches,
   output int         pending,
   output int         chars_checked,
   output int         newlines_seen
);
   import b64le_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } char_beat_type;

   char_beat_type due_chars[$];
   char_beat_type want;
   logic [7:0] byte_a;
   logic [7:0] byte_b;
   logic [1:0] held_n;
   logic [7:0] line_chars;
   logic [7:0] line_limit;
   int         bad_n;
   int         got_n;
   int         nl_n;

   function automatic logic [7:0] digit(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (v < 6'd26) begin
         return "A" + w;
      end else if (v < 6'd52) begin
         return "a" + w - 8'd26;
      end else if (v < 6'd62) begin
         return "0" + w - 8'd52;
      end else if (v == 6'd62) begin
         return "+";
      end
      return "/";
   endfunction

   task automatic absorb_byte(input logic [7:0] b, input logic fin);
      logic [7:0] g0;
      logic [7:0] g1;
      logic [7:0] g2;
      logic [7:0] enc [5];
      int         n;
      int         run;
      if (held_n < 2'd2 && !fin) begin
         if (held_n == 2'd0) begin
            byte_a = b;
         end else begin
            byte_b = b;
         end
         held_n = held_n + 2'd1;
         return;
      end
      g0 = (held_n == 2'd0) ? b : byte_a;
      g1 = (held_n == 2'd0) ? 8'h00 : ((held_n == 2'd1) ? b : byte_b);
      g2 = (held_n == 2'd2) ? b : 8'h00;
      enc[0] = digit(g0[7:2]);
      enc[1] = digit({g0[1:0], g1[7:4]});
      enc[2] = (held_n != 2'd0) ? digit({g1[3:0], g2[7:6]}) : PadChar;
      enc[3] = (held_n == 2'd2) ? digit(g2[5:0]) : PadChar;
      n = 4;
      run = int'(line_chars) + 4;
      if (run + 4 > int'(line_limit)) begin
         enc[4] = NewlineChar;
         n = 5;
         run = 0;
      end
      line_chars = run[7:0];
      if (fin) begin
         line_chars = 8'd0;
      end
      held_n = 2'd0;
      byte_a = 8'h00;
      byte_b = 8'h00;
      for (int k = 0; k < n; k++) begin
         due_chars.push_back('{ch: enc[k], fin: (k == n - 1)});
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         due_chars.delete();
         byte_a = 8'h00;
         byte_b = 8'h00;
         held_n = 2'd0;
         line_chars = 8'd0;
         line_limit = MaxLineCharsReset;
         bad_n = 0;
         got_n = 0;
         nl_n = 0;
      end else begin
         if (csr_wr_en) begin
            line_limit = csr_wr_data;
         end
         // drain first: a character beat never stems from a byte beat of the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_chars.size() == 0) begin
               bad_n++;
               if (bad_n <= 10) begin
                  $display("unexpected char beat: 0x%02h last=%0b",
                           rsp_mon.out_char, rsp_mon.last_of_run);
               end
            end else begin
               want = due_chars.pop_front();
               if (want.ch == NewlineChar) begin
                  nl_n++;
               end
               if (want.ch !== rsp_mon.out_char || want.fin !== rsp_mon.last_of_run) begin
                  bad_n++;
                  if (bad_n <= 10) begin
                     $display("char %0d: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                              got_n, want.ch, want.fin, rsp_mon.out_char,
                              rsp_mon.last_of_run);
                  end
               end
            end
            got_n++;
         end
         if (req_mon.valid && req_mon.ready) begin
            absorb_byte(req_mon.data_byte, req_mon.last_byte);
         end
      end
      mismatches <= bad_n;
      pending <= due_chars.size();
      chars_checked <= got_n;
      newlines_seen <= nl_n;
   end

endmodule

// File: tb/base64_line_wrapped_encoder_test.sv
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder_test
// Drives byte messages into the encoder in bursts with random gaps while the
// character side stalls on its own pattern. Directed messages cover every
// pad length, extreme byte values, tight and out-of-range line limits and
// the line count restarting at message end; random messages follow under
// several limits, 4 and 255 among them. Checking is done by the stream
// checker; this top makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module base64_line_wrapped_encoder_test;
   import b64le_pkg::*;

   localparam int StallLimit   = 4000;
   localparam int ByteTarget   = 380;
   localparam int SettleCycles = 16;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   b64le_req_if req_bus ();
   b64le_rsp_if rsp_bus ();

   int mismatches;
   int pending;
   int chars_checked;
   int newlines_seen;
   int bytes_sent = 0;
   int messages_sent = 0;
   int limits_written = 0;
   int burst_left = 0;
   int rdy_left = 0;
   int quiet_cycles = 0;

   base64_line_wrapped_encoder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   b64le_stream_checker u_score (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .mismatches    (mismatches),
      .pending       (pending),
      .chars_checked (chars_checked),
      .newlines_seen (newlines_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // character side: stalls, long ready stretches and short flicker
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rdy_left <= 0;
      end else if (rdy_left == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               rsp_bus.ready <= 1'b0;
               rdy_left <= $urandom_range(1, 12);
            end
            1: begin
               rsp_bus.ready <= 1'b1;
               rdy_left <= $urandom_range(20, 60);
            end
            default: begin
               rsp_bus.ready <= 1'($urandom_range(0, 1));
               rdy_left <= $urandom_range(0, 3);
            end
         endcase
      end else begin
         rdy_left <= rdy_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == StallLimit) begin
         $display("base64_line_wrapped_encoder test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic fin);
      int gap;
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= fin;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
      bytes_sent++;
      if (fin) begin
         messages_sent++;
      end
   endtask

   task automatic send_message(input int len);
      int         pick;
      logic [7:0] b;
      pick = $urandom_range(0, 7);
      for (int i = 0; i < len; i++) begin
         if (pick == 0) begin
            b = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         end else begin
            b = 8'($urandom_range(0, 255));
         end
         send_beat(b, i == len - 1);
      end
   endtask

   // limit changes only once the encoder has drained
   task automatic settle_and_write(input logic [7:0] v);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limits_written++;
   endtask

   initial begin
      int         phase;
      int         phase_bytes;
      int         len;
      logic [7:0] lim;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 8'h00;
      req_bus.valid = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.last_byte = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset limit: one, two and three byte groups
      send_beat(8'h00, 1'b1);
      send_beat(8'hFF, 1'b0);
      send_beat(8'hFF, 1'b1);
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h80, 1'b1);
      send_beat(8'hFF, 1'b1);

      // tightest legal limit: newline after every group
      settle_and_write(8'd4);
      send_beat(8'hFC, 1'b0);
      send_beat(8'h03, 1'b0);
      send_beat(8'h0F, 1'b0);
      send_beat(8'h3F, 1'b0);
      send_beat(8'hAA, 1'b0);
      send_beat(8'h55, 1'b1);

      // two groups per line, count restarts after the padded tail
      settle_and_write(8'd8);
      for (int i = 1; i <= 7; i++) begin
         send_beat(8'(i), i == 7);
      end

      // below the legal range
      settle_and_write(8'd2);
      send_beat(8'h12, 1'b0);
      send_beat(8'h34, 1'b0);
      send_beat(8'h56, 1'b1);

      phase = 0;
      phase_bytes = 0;
      settle_and_write(8'd255);
      while (bytes_sent < ByteTarget) begin
         if (phase_bytes >= 60) begin
            phase++;
            phase_bytes = 0;
            case ($urandom_range(0, 4))
               0: lim = 8'd4;
               1: lim = 8'd76;
               2: lim = 8'd12;
               default: lim = 8'($urandom_range(4, 255));
            endcase
            if (phase == 1) begin
               lim = 8'd4;
            end
            settle_and_write(lim);
         end
         case ($urandom_range(0, 9))
            6, 7, 8: len = $urandom_range(13, 60);
            9: len = $urandom_range(150, 200);
            default: len = $urandom_range(1, 12);
         endcase
         if (len > ByteTarget - bytes_sent) begin
            len = ByteTarget - bytes_sent;
         end
         send_message(len);
         phase_bytes += len;
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("sent %0d bytes in %0d messages under %0d line-limit settings",
               bytes_sent, messages_sent, limits_written);
      $display("checked %0d characters, %0d of them newlines", chars_checked, newlines_seen);
      if (mismatches == 0 && pending == 0) begin
         $display("base64_line_wrapped_encoder test passed");
      end else begin
         $display("base64_line_wrapped_encoder test failed");
      end
      $finish;
   end

endmodule
